// ===== hw/rtl/cgdu_pkg.sv =====
// shared types and constants for the cg direction update block
package cgdu_pkg;
    localparam int unsigned IN_TDATA_W  = 192;
    localparam int unsigned OUT_TDATA_W = 160;

    // command from controller to datapath
    typedef struct packed {
        logic load;      // capture item and start
        logic mul_step;  // advance multiply sequence
        logic acc;       // fold item into accumulators
        logic root_go;   // start square root
        logic div_go;    // start slope division
        logic finish;    // form result and clear on last
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic root_done;
        logic div_done;
        logic last;
    } t_status;
endpackage

// ===== hw/rtl/cgdu_datapath.sv =====
// datapath: multiplies, accumulators, square root and divider
module cgdu_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cgdu_pkg::t_cmd                i_cmd,
    output cgdu_pkg::t_status             o_status,
    input  logic                          i_cfg_valid,
    input  logic [31:0]                   i_cfg_data,
    input  logic [cgdu_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic                          i_in_last,
    output logic [cgdu_pkg::OUT_TDATA_W-1:0] o_res_data,
    output logic                          o_res_last
);
    import cgdu_pkg::*;

    logic signed [31:0] r_beta;
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_h [3];
    logic signed [31:0] r_nd [3];
    logic               r_last;
    logic [2:0]         r_step;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_item_dot;
    logic [63:0]        r_nsq;
    logic signed [63:0] r_dot;
    logic [63:0]        r_max;
    // sqrt
    logic [63:0] r_sq_n, r_sq_res, r_sq_bit;
    logic        r_sq_busy, r_root_done;
    // divider
    logic [95:0] r_dv_rem;
    logic [6:0]  r_dv_cnt;
    logic [32:0] r_dv_q;
    logic        r_dv_busy, r_div_done, r_dv_ovf, r_dv_neg;
    logic [31:0] r_maxlen;
    logic [OUT_TDATA_W-1:0] r_res;

    // multiply sequence: steps 0-2 beta*h, 3-5 f*nd and nd*nd
    logic [1:0] w_k;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_mul;
    logic signed [63:0] w_sh;
    logic signed [63:0] w_sum;
    logic signed [31:0] w_sat;
    logic signed [63:0] w_sq;
    logic [64:0]        w_nsq_sum;

    always_comb begin
        w_k  = (r_step < 3'd3) ? r_step[1:0] : 2'(r_step - 3'd3);
        w_ma = (r_step < 3'd3) ? r_beta : r_f[w_k];
        w_mb = (r_step < 3'd3) ? r_h[w_k] : r_nd[w_k];
    end
    assign w_mul = w_ma * w_mb;
    assign w_sh  = r_prod >>> FRAC_BITS;
    assign w_sq  = r_nd[w_k] * r_nd[w_k];
    assign w_sum = 64'(r_f[w_k]) + w_sh;
    assign w_sat = (w_sum > 64'sd2147483647) ? 32'sh7fffffff :
                   (w_sum < -64'sd2147483648) ? 32'sh80000000 : w_sum[31:0];
    assign w_nsq_sum = {1'b0, r_nsq} + {1'b0, w_sq};

    logic [3:0] r_phase; // pipeline of product register use
    logic signed [63:0] w_acc_sum;
    logic w_ovf;
    assign w_acc_sum = r_dot + r_item_dot;
    assign w_ovf = (r_dot[63] == r_item_dot[63]) && (w_acc_sum[63] != r_dot[63]);

    logic [63:0] w_sq_t;
    assign w_sq_t = r_sq_res + r_sq_bit;

    // long division partial remainder and trial subtract
    logic [32:0] r_pr;
    logic [33:0] w_trial;
    assign w_trial = {r_pr, r_dv_rem[95]} - {2'b0, r_maxlen};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= '0; r_dot <= '0; r_max <= '0;
            r_sq_busy <= 1'b0; r_root_done <= 1'b0;
            r_dv_busy <= 1'b0; r_div_done <= 1'b0;
            r_step <= '0; r_phase <= '0;
        end else begin
            if (i_cfg_valid) r_beta <= i_cfg_data;
            r_root_done <= 1'b0;
            r_div_done  <= 1'b0;
            if (i_cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    r_f[i] <= i_in_data[32*i +: 32];
                    r_h[i] <= i_in_data[96+32*i +: 32];
                end
                r_last <= i_in_last;
                r_step <= '0; r_phase <= '0;
                r_item_dot <= '0; r_nsq <= '0;
            end else if (i_cmd.mul_step) begin
                // phase 0: multiply into r_prod; phase 1: consume
                if (r_phase == 4'd0) begin
                    r_prod <= w_mul;
                    r_phase <= 4'd1;
                end else begin
                    if (r_step < 3'd3) r_nd[w_k] <= w_sat;
                    else begin
                        r_item_dot <= r_item_dot + w_sh;
                        r_nsq <= w_nsq_sum[63:0];
                    end
                    r_step <= r_step + 3'd1;
                    r_phase <= 4'd0;
                end
            end
            if (i_cmd.acc) begin
                r_dot <= w_ovf ? (r_dot[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                               : w_acc_sum;
                if (r_nsq > r_max) r_max <= r_nsq;
            end
            if (i_cmd.root_go) begin
                r_sq_n <= r_max; r_sq_res <= '0; r_sq_bit <= 64'd1 << 62;
                r_sq_busy <= 1'b1;
            end else if (r_sq_busy) begin
                if (r_sq_bit == 64'd0) begin
                    r_sq_busy <= 1'b0; r_root_done <= 1'b1;
                    r_maxlen <= r_sq_res[31:0];
                end else begin
                    if (r_sq_n >= w_sq_t) begin
                        r_sq_n <= r_sq_n - w_sq_t;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else r_sq_res <= r_sq_res >> 1;
                    r_sq_bit <= r_sq_bit >> 2;
                end
            end
            if (i_cmd.div_go) begin
                // restoring divide of |dot|<<FRAC_BITS, 96 bits, 33-bit quotient
                r_dv_neg <= (r_dot > 0);
                r_dv_rem <= 96'($unsigned(r_dot[63] ? -r_dot : r_dot)) << FRAC_BITS;
                r_dv_q <= '0; r_dv_ovf <= 1'b0;
                r_pr <= '0;
                r_dv_cnt <= 7'd96;
                r_dv_busy <= (r_maxlen != 32'd0);
                r_div_done <= (r_maxlen == 32'd0);
            end else if (r_dv_busy) begin
                if (r_dv_cnt == 7'd0) begin
                    r_dv_busy <= 1'b0; r_div_done <= 1'b1;
                end else begin
                    r_dv_cnt <= r_dv_cnt - 7'd1;
                    r_dv_rem <= r_dv_rem << 1;
                    if (r_dv_q[32]) r_dv_ovf <= 1'b1;
                    if (!w_trial[33]) begin
                        r_pr <= w_trial[32:0];
                        r_dv_q <= {r_dv_q[31:0], 1'b1};
                    end else begin
                        r_pr <= {r_pr[31:0], r_dv_rem[95]};
                        r_dv_q <= {r_dv_q[31:0], 1'b0};
                    end
                end
            end
            if (i_cmd.finish && r_last) begin
                r_dot <= '0; r_max <= '0;
            end
        end
    end

    logic [32:0] w_q;
    logic [31:0] w_slope;
    always_comb begin
        w_q = (r_dv_ovf || (r_dv_q > 33'h100000000)) ? 33'h100000000 : r_dv_q;
        if (r_maxlen == 32'd0) w_slope = '0;
        else if (r_dv_neg) w_slope = (w_q >= 33'h080000000) ? 32'h80000000 : 32'(-w_q);
        else w_slope = (w_q > 33'h07fffffff) ? 32'h7fffffff : w_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= {r_last ? w_slope : 32'd0, r_last ? r_maxlen : 32'd0,
                      r_nd[2], r_nd[1], r_nd[0]};
        end
    end

    assign o_status.mul_done  = (r_step == 3'd6);
    assign o_status.root_done = r_root_done;
    assign o_status.div_done  = r_div_done;
    assign o_status.last      = r_last;
    assign o_res_data = r_res;
    assign o_res_last = r_last;
endmodule

// ===== hw/rtl/cgdu_ctrl.sv =====
// controller state machine for the cg direction update block
module cgdu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cgdu_pkg::t_cmd    o_cmd,
    input  cgdu_pkg::t_status i_status
);
    import cgdu_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_ROOT, S_DIV, S_FIN, S_OUT} t_state;
    t_state r_state;

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_step = (r_state == S_MUL) && !i_status.mul_done;
        o_cmd.acc      = (r_state == S_MUL) && i_status.mul_done;
        o_cmd.root_go  = (r_state == S_ACC) && i_status.last;
        o_cmd.div_go   = (r_state == S_ROOT) && i_status.root_done;
        o_cmd.finish   = (r_state == S_FIN);
    end
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_MUL;
                S_MUL:  if (i_status.mul_done) r_state <= S_ACC;
                S_ACC:  r_state <= i_status.last ? S_ROOT : S_FIN;
                S_ROOT: if (i_status.root_done) r_state <= S_DIV;
                S_DIV:  if (i_status.div_done) r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_MUL) else $error("load did not start multiply");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input taken while result pending");
endmodule

// ===== hw/rtl/cg_direction_update_reduce_top.sv =====
// top level of the cg direction update and sweep reduction block
// for an item not last, the result follows six multiply steps, each a
// multiply phase and a consume phase, then accumulate and format;
// a last item adds a square root and a slope division
// one item at a time; next item accepted after the result is taken
// reset: synchronous active low, clears beta and both accumulators
module cg_direction_update_reduce_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,   // beta_coef
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // force_x, force_y, force_z, old_dir_x, old_dir_y, old_dir_z
    input  logic [cgdu_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic         s_axis_tlast,  // last_particle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_dir_x, new_dir_y, new_dir_z, max_length, slope_out
    output logic [cgdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic         m_axis_tlast   // sweep_done
);
    import cgdu_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // config always accepted
    assign o_cfg_ready = 1'b1;

    cgdu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd), .i_status(w_status)
    );

    cgdu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_cfg_valid, .i_cfg_data,
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .o_res_data(m_axis_tdata), .o_res_last(m_axis_tlast)
    );
endmodule

// ===== sim/cg_direction_update_reduce_top_tb.sv =====
// testbench for the cg direction update and sweep reduction block
`timescale 1ns / 1ps

module cg_direction_update_reduce_top_tb;
    localparam int FRAC_BITS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // packed from the top down, matching {m_axis_tdata, m_axis_tlast}
    typedef struct packed {
        logic [31:0] slope_out;
        logic [31:0] max_length;
        logic [31:0] new_dir_z;
        logic [31:0] new_dir_y;
        logic [31:0] new_dir_x;
        logic        sweep_done;
    } t_dir_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // force_x, force_y, force_z, old_dir_x, old_dir_y, old_dir_z
    logic [cgdu_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;  // last_particle
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // new_dir_x, new_dir_y, new_dir_z, max_length, slope_out
    logic [cgdu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic         m_axis_tlast;         // sweep_done

    cg_direction_update_reduce_top #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // predictor state: beta plus the two sweep accumulators
    logic signed [31:0]  beta_q;
    logic signed [63:0]  dot_sum;
    logic        [63:0]  max_nsq;
    t_dir_result         pending_dirs[$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    bit                  sink_stall_on = 1'b1;   // random idling on the result side
    bit                  src_gaps_on = 1'b1;
    int                  long_hold = 0;          // cycles the receiver holds off

    // floor of the integer square root, bit by bit
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv, rem;
        res = 0; rem = n; bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // computes the expected result of one particle and advances the sweep state
    function automatic t_dir_result update_direction(input logic [191:0] pkt, input logic lst);
        t_dir_result r;
        logic signed [63:0] f, h, nd, item_dot, sum;
        logic [63:0] nsq, maxlen, mag, qh, rm, q;
        logic signed [31:0] dirs[3];
        item_dot = 0; nsq = 0;
        for (int k = 0; k < 3; k++) begin
            f = $signed(pkt[32*k +: 32]);
            h = $signed(pkt[32*(k+3) +: 32]);
            nd = clamp32(f + ((64'(beta_q) * h) >>> FRAC_BITS));
            dirs[k] = nd[31:0];
            item_dot = item_dot + ((f * nd) >>> FRAC_BITS);
            nsq = nsq + 64'(nd * nd);
        end
        // saturating 64-bit accumulate
        sum = dot_sum + item_dot;
        if (item_dot > 0 && dot_sum > 0 && sum < 0) sum = 64'sh7fffffffffffffff;
        else if (item_dot < 0 && dot_sum < 0 && sum >= 0) sum = 64'sh8000000000000000;
        dot_sum = sum;
        if (nsq > max_nsq) max_nsq = nsq;
        r = '0;
        r.new_dir_x = dirs[0]; r.new_dir_y = dirs[1]; r.new_dir_z = dirs[2];
        r.sweep_done = lst;
        if (lst) begin
            maxlen = int_sqrt(max_nsq);
            r.max_length = maxlen[31:0];
            if (maxlen != 0) begin
                mag = (dot_sum < 0) ? -dot_sum : dot_sum;
                qh = mag / maxlen;
                rm = mag % maxlen;
                if (qh >= 64'h1_0000_0000) q = 64'h1_0000_0000;
                else begin
                    q = (qh << FRAC_BITS) + ((rm << FRAC_BITS) / maxlen);
                    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
                end
                if (dot_sum > 0)
                    r.slope_out = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
                else
                    r.slope_out = (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
            end
            dot_sum = 0;
            max_nsq = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // one particle per call; optional random gap before offering it
    task automatic send_particle(input logic [191:0] pkt, input logic lst);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pkt;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_dirs.push_back(update_direction(pkt, lst));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);   // extra idle time after the last result has been taken
    endtask

    task automatic write_beta(input logic [31:0] b);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= b;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        beta_q = b;
    endtask

    function automatic logic [31:0] rand_field(input int mode);
        case (mode)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 2000 << 16)) - (1000 << 16));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [191:0] rand_particle();
        logic [191:0] p;
        for (int k = 0; k < 6; k++)
            p[32*k +: 32] = rand_field($urandom_range(0, 9) < 2 ? $urandom_range(0, 1)
                                       : $urandom_range(2, 3));
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_dir_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tlast};
            if (pending_dirs.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = pending_dirs.pop_front();
                if (got.new_dir_x != want.new_dir_x)
                    report_mismatch("new_dir_x", got.new_dir_x, want.new_dir_x);
                if (got.new_dir_y != want.new_dir_y)
                    report_mismatch("new_dir_y", got.new_dir_y, want.new_dir_y);
                if (got.new_dir_z != want.new_dir_z)
                    report_mismatch("new_dir_z", got.new_dir_z, want.new_dir_z);
                if (got.max_length != want.max_length)
                    report_mismatch("max_length", got.max_length, want.max_length);
                if (got.slope_out != want.slope_out)
                    report_mismatch("slope_out", got.slope_out, want.slope_out);
                if (got.sweep_done != want.sweep_done)
                    report_mismatch("sweep_done", 32'(got.sweep_done), 32'(want.sweep_done));
            end
        end
    end

    // receiver: long hold-off when asked, else bursts of stall
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                m_axis_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted item anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cg_direction_update_reduce_top_tb: done, errors");
            $finish;
        end
    end

    // extremes of every field, sweep of one, zero direction, clearing
    task automatic test_directed();
        logic [31:0] ext[4];
        ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000};
        write_beta(32'h0001_0000);
        send_particle('0, 1'b1);                       // zero maximum gives zero slope
        for (int i = 0; i < 4; i++)
            send_particle({6{ext[i]}}, i[0]);
        send_particle({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000}, 1'b1);
        send_particle({32'hffff_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000}, 1'b1);
        send_particle({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1);
        send_particle({32'hffff_ffff, 32'h0, 32'h1, 32'h1, 32'h0, 32'hffff_ffff}, 1'b1);
        wait_drained();
        write_beta(32'h8000_0000);
        for (int i = 0; i < 4; i++) send_particle({6{ext[i]}}, i == 3);
        wait_drained();
        write_beta(32'h7fff_ffff);
        for (int i = 0; i < 4; i++) send_particle({6{ext[3 - i]}}, i == 3);
        wait_drained();
    endtask

    // random sweeps under one given beta setting
    task automatic test_random_sweeps(input int n, input logic [31:0] b);
        write_beta(b);
        for (int i = 0; i < n; i++)
            send_particle(rand_particle(), $urandom_range(0, 7) == 0 || i == n - 1);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        long_hold = 200;
        for (int i = 0; i < 20; i++) send_particle(rand_particle(), i % 5 == 4);
        wait_drained();
    endtask

    initial begin
        beta_q = 0; dot_sum = 0; max_nsq = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_sweeps(150, 32'h0000_8000);
        test_backpressure();
        test_random_sweeps(150, $urandom());
        test_random_sweeps(150, 32'hffff_4000);
        sink_stall_on = 1'b0;
        src_gaps_on = 1'b0;
        test_random_sweeps(150, 32'h0);
        wait_drained();
        if (error_count == 0)
            $display("cg_direction_update_reduce_top_tb: done, clean");
        else
            $display("cg_direction_update_reduce_top_tb: done, errors");
        $finish;
    end
endmodule
